/* rtl/core/unsorted_array_max_priority_queue_top_assert.svh */
// Assertion macros for the unsorted array max priority queue.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef UNSORTED_ARRAY_MAX_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define UNSORTED_ARRAY_MAX_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define UAMQ_ASSERT(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
`define UAMQ_NEVER(lbl, ck, rstn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define UAMQ_ASSERT(lbl, ck, rstn, prop, msg)
`define UAMQ_NEVER(lbl, ck, rstn, cond, msg)
`endif
`endif

/* rtl/core/uamq_pkg.sv */
// Shared constants, codes and types for the unsorted array max priority queue.
// No dependencies.
`default_nettype none

package uamq_pkg;

    localparam int CAPACITY  = 64;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 7;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_RAW_W = $clog2(CAPACITY + 1);
    localparam int CNT_W     = (CNT_RAW_W > OCC_W) ? CNT_RAW_W : OCC_W;

    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EXTRACT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_MODIFY  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wval;
        logic [DATA_W-1:0] wpri;
        logic [IDX_W-1:0]  raddr;
    } uamq_mem_req_t;

endpackage

`default_nettype wire

/* rtl/core/unsorted_array_max_priority_queue_top.sv */
// Max priority queue over an unsorted entry array.
// Input channel takes one request word (insert, extract max, peek max, modify by
// value); output channel returns one result word per request (value, status,
// occupancy). Both channels use valid/stall; a word moves when valid is high
// and stall is low.
// Insert, and any request that finds the queue empty or full, goes straight to
// the result; peek max and modify scan the stored entries (modify stops at the
// first match); extract max scans, then moves the last entry into the freed slot.
// The single read port of the entry store sets the pace of a scan: one entry is
// read and compared per cycle. One request is in flight at a time; in_stall is
// high from accept until the result is loaded into the output register, so a
// new request is accepted only once the last one has finished.
// A stalled output holds its word; the next request may be accepted while it
// waits, and its result waits in turn until the output register frees up.
// Reset clears the state, the entry count, the pending-read flag and the
// output valid flag; the store is not cleared.
// Depends on uamq_pkg, uamq_store and the assertion macro header.
`default_nettype none

module unsorted_array_max_priority_queue_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [uamq_pkg::REQ_W-1:0]     req_type,
    input  wire logic [uamq_pkg::DATA_W-1:0]    item_value,
    input  wire logic [uamq_pkg::DATA_W-1:0]    item_priority,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [uamq_pkg::DATA_W-1:0]         out_value,
    output logic [uamq_pkg::STATUS_W-1:0]       status,
    output logic [uamq_pkg::OCC_W-1:0]          occupancy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam int IDX_W  = uamq_pkg::IDX_W;
    localparam int CNT_W  = uamq_pkg::CNT_W;
    localparam int DATA_W = uamq_pkg::DATA_W;

    logic [2:0]                       state_reg, state_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             pend_reg, pend_next;
    logic                             out_valid_reg, out_valid_next;

    logic [uamq_pkg::REQ_W-1:0]       req_reg;
    logic [DATA_W-1:0]                val_reg, pri_reg;
    logic [CNT_W-1:0]                 issue_reg, issue_next;
    logic [IDX_W-1:0]                 pend_idx_reg, pend_idx_next;
    logic [DATA_W-1:0]                best_val_reg, best_val_next;
    logic [DATA_W-1:0]                best_pri_reg, best_pri_next;
    logic [IDX_W-1:0]                 best_idx_reg, best_idx_next;
    logic [DATA_W-1:0]                res_val_reg, res_val_next;
    logic [uamq_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [DATA_W-1:0]                out_value_reg, out_value_next;
    logic [uamq_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [uamq_pkg::OCC_W-1:0]       occupancy_reg, occupancy_next;

    uamq_pkg::uamq_mem_req_t          mem_req;
    logic [DATA_W-1:0]                rd_val, rd_pri;

    logic                             accept;
    logic [CNT_W-1:0]                 cnt_m1;
    logic [IDX_W-1:0]                 last_idx;
    logic                             first, higher, hit, scan_end, out_free, take;

    uamq_store u_store
    (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_val  (rd_val),
        .rd_pri  (rd_pri)
    );

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign cnt_m1   = cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign first    = (pend_idx_reg == '0);
    assign higher   = ($signed(rd_pri) > $signed(best_pri_reg));
    assign hit      = (rd_val == val_reg);
    assign scan_end = pend_reg && (pend_idx_reg == last_idx);
    assign out_free = !out_valid_reg || !out_stall;
    assign take     = first || higher;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = issue_reg[IDX_W-1:0];
        best_val_next   = best_val_reg;
        best_pri_next   = best_pri_reg;
        best_idx_next   = best_idx_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_value_next  = out_value_reg;
        status_next     = status_reg;
        occupancy_next  = occupancy_reg;
        mem_req.we      = 1'b0;
        mem_req.waddr   = '0;
        mem_req.wval    = '0;
        mem_req.wpri    = '0;
        mem_req.raddr   = issue_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_val_next    = '0;
                    res_status_next = uamq_pkg::ST_OK;
                    issue_next      = '0;
                    state_next      = S_FIN;
                    unique case (req_type)
                        uamq_pkg::REQ_INSERT:
                        begin
                            if (cnt_reg >= CNT_W'(uamq_pkg::CAPACITY))
                            begin
                                res_status_next = uamq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = cnt_reg[IDX_W-1:0];
                                mem_req.wval  = item_value;
                                mem_req.wpri  = item_priority;
                                cnt_next      = cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        uamq_pkg::REQ_EXTRACT, uamq_pkg::REQ_PEEK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = uamq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        uamq_pkg::REQ_MODIFY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = uamq_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue_reg < cnt_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                end
                if (pend_reg)
                begin
                    if (req_reg == uamq_pkg::REQ_MODIFY)
                    begin
                        if (hit)
                        begin
                            mem_req.we      = 1'b1;
                            mem_req.waddr   = pend_idx_reg;
                            mem_req.wval    = val_reg;
                            mem_req.wpri    = pri_reg;
                            res_status_next = uamq_pkg::ST_OK;
                            pend_next       = 1'b0;
                            state_next      = S_FIN;
                        end
                        else if (scan_end)
                        begin
                            res_status_next = uamq_pkg::ST_NOTFOUND;
                            pend_next       = 1'b0;
                            state_next      = S_FIN;
                        end
                    end
                    else
                    begin
                        if (take)
                        begin
                            best_val_next = rd_val;
                            best_pri_next = rd_pri;
                            best_idx_next = pend_idx_reg;
                        end
                        if (scan_end)
                        begin
                            pend_next = 1'b0;
                            if (req_reg == uamq_pkg::REQ_EXTRACT)
                            begin
                                state_next = S_LAST;
                            end
                            else
                            begin
                                res_val_next = take ? rd_val : best_val_reg;
                                state_next   = S_FIN;
                            end
                        end
                    end
                end
            end
            S_LAST:
            begin
                mem_req.raddr = last_idx;
                state_next    = S_MOVE;
            end
            S_MOVE:
            begin
                // last entry fills the freed slot
                mem_req.we      = 1'b1;
                mem_req.waddr   = best_idx_reg;
                mem_req.wval    = rd_val;
                mem_req.wpri    = rd_pri;
                cnt_next        = cnt_m1;
                res_val_next    = best_val_reg;
                res_status_next = uamq_pkg::ST_OK;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_val_reg;
                    status_next    = res_status_reg;
                    occupancy_next = cnt_reg[uamq_pkg::OCC_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            val_reg <= item_value;
            pri_reg <= item_priority;
        end
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        best_val_reg   <= best_val_next;
        best_pri_reg   <= best_pri_next;
        best_idx_reg   <= best_idx_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        status_reg     <= status_next;
        occupancy_reg  <= occupancy_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

`include "unsorted_array_max_priority_queue_top_assert.svh"

    `UAMQ_ASSERT(a_cnt_cap, clk, rst_n,
        (cnt_reg <= CNT_W'(uamq_pkg::CAPACITY)), "count over capacity")
    `UAMQ_ASSERT(a_full_only_at_cap, clk, rst_n,
        ((state_reg == S_FIN) && (res_status_reg == uamq_pkg::ST_FULL))
            |-> (cnt_reg == CNT_W'(uamq_pkg::CAPACITY)),
        "full status below capacity")
    `UAMQ_ASSERT(a_move_dec, clk, rst_n,
        (state_reg == S_MOVE) |=> (cnt_reg == $past(cnt_m1)),
        "extract did not drop one entry")
    `UAMQ_NEVER(a_peek_no_write, clk, rst_n,
        (state_reg == S_SCAN) && (req_reg == uamq_pkg::REQ_PEEK) && mem_req.we,
        "peek wrote the store")

endmodule

`default_nettype wire

/* rtl/core/uamq_store.sv */
// Entry store: one write port, one registered read port, value and priority per slot.
// Depends on uamq_pkg.
`default_nettype none

module uamq_store
(
    input  wire logic                         clk,
    input  wire uamq_pkg::uamq_mem_req_t      mem_req,
    output logic [uamq_pkg::DATA_W-1:0]       rd_val,
    output logic [uamq_pkg::DATA_W-1:0]       rd_pri
);

    logic [2*uamq_pkg::DATA_W-1:0] mem [uamq_pkg::CAPACITY];
    logic [2*uamq_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= {mem_req.wval, mem_req.wpri};
        end
        rdata_reg <= mem[mem_req.raddr];
    end

    assign rd_val = rdata_reg[2*uamq_pkg::DATA_W-1:uamq_pkg::DATA_W];
    assign rd_pri = rdata_reg[uamq_pkg::DATA_W-1:0];

endmodule

`default_nettype wire
